FILE: rtl/quoted_line_tokenizer_macros.svh
// Assertion macros used by the checker file of the line tokenizer.
`ifndef QUOTED_LINE_TOKENIZER_MACROS_SVH
`define QUOTED_LINE_TOKENIZER_MACROS_SVH

// Same-cycle implication, sampled on the rising clock edge.
`define QLT_ASSERT_IMP(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("assertion failed");

// Next-cycle implication, sampled on the rising clock edge.
`define QLT_ASSERT_NXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("assertion failed");

`endif

FILE: rtl/qlt_pkg.sv
// Types and constants of the quoted line tokenizer.
`default_nettype none

package qlt_pkg;

    localparam logic [7:0] CHR_HASH   = 8'h23;
    localparam logic [7:0] CHR_BSLASH = 8'h5C;
    localparam logic [7:0] CHR_SQUOTE = 8'h27;
    localparam logic [7:0] CHR_DQUOTE = 8'h22;
    localparam logic [7:0] CHR_SPACE  = 8'h20;
    localparam logic [7:0] CHR_TAB    = 8'h09;
    localparam logic [7:0] CHR_CR     = 8'h0D;

    localparam int unsigned CNT_W       = 4;
    localparam logic [CNT_W-1:0] CNT_MAX = '1;
    localparam logic [CNT_W-1:0] MAX_TOKENS_RST = 4'd10;

    // Register index of max_tokens on the configuration port.
    localparam logic REG_MAX_TOKENS = 1'b0;

    typedef enum logic [2:0] {
        PH_LEAD,
        PH_START,
        PH_TOKEN,
        PH_QUOTED,
        PH_DONE
    } t_phase;

    typedef enum logic [1:0] {
        ST_OK,
        ST_COMMENT,
        ST_QUOTE_ERR,
        ST_LIMIT
    } t_status;

    typedef struct packed {
        t_phase           phase;
        logic             quote_dbl;
        logic             esc;
        logic [CNT_W-1:0] count;
        t_status          status;
    } t_state;

    localparam t_state STATE_RST = '{
        phase:     PH_LEAD,
        quote_dbl: 1'b0,
        esc:       1'b0,
        count:     '0,
        status:    ST_OK
    };

    typedef struct packed {
        logic [1:0]       line_status;
        logic [CNT_W-1:0] token_count;
        logic [CNT_W-1:0] token_index;
        logic             token_close;
        logic             in_token;
        logic [7:0]       char_out;
    } t_result;

endpackage

`default_nettype wire

FILE: rtl/qlt_step.sv
// Per-byte next-state and result logic of the line tokenizer.
`default_nettype none

module qlt_step (
    input  var qlt_pkg::t_state  i_state,
    input  wire logic [7:0]      i_char,
    input  wire logic            i_last,
    input  wire logic [3:0]      i_max_tokens,
    output qlt_pkg::t_state      o_state,
    output qlt_pkg::t_result     o_result
);

    logic                          ws;
    logic                          quote;
    logic                          content;
    logic                          closed;
    logic [qlt_pkg::CNT_W-1:0]     lim;
    logic [qlt_pkg::CNT_W-1:0]     idx;
    logic [7:0]                    close_chr;
    qlt_pkg::t_state               nxt;

    assign ws    = (i_char == qlt_pkg::CHR_SPACE) ||
                   (i_char >= qlt_pkg::CHR_TAB && i_char <= qlt_pkg::CHR_CR);
    assign quote = (i_char == qlt_pkg::CHR_SQUOTE) || (i_char == qlt_pkg::CHR_DQUOTE);
    assign lim   = (i_max_tokens == '0) ? qlt_pkg::CNT_W'(1) : i_max_tokens;
    assign close_chr = i_state.quote_dbl ? qlt_pkg::CHR_DQUOTE : qlt_pkg::CHR_SQUOTE;

    always_comb begin
        nxt     = i_state;
        nxt.esc = 1'b0;
        content = 1'b0;
        closed  = 1'b0;
        idx     = '0;

        if (i_state.esc &&
            (i_state.phase == qlt_pkg::PH_TOKEN || i_state.phase == qlt_pkg::PH_QUOTED)) begin
            content = 1'b1;
        end else begin
            case (i_state.phase)
                qlt_pkg::PH_LEAD, qlt_pkg::PH_START: begin
                    if (ws) begin
                        nxt.phase = i_state.phase;
                    end else if (i_state.phase == qlt_pkg::PH_LEAD &&
                                 i_char == qlt_pkg::CHR_HASH) begin
                        nxt.status = qlt_pkg::ST_COMMENT;
                        nxt.phase  = qlt_pkg::PH_DONE;
                    end else if (quote) begin
                        nxt.quote_dbl = (i_char == qlt_pkg::CHR_DQUOTE);
                        nxt.phase     = qlt_pkg::PH_QUOTED;
                    end else begin
                        content   = 1'b1;
                        nxt.phase = qlt_pkg::PH_TOKEN;
                        nxt.esc   = (i_char == qlt_pkg::CHR_BSLASH);
                    end
                end
                qlt_pkg::PH_TOKEN: begin
                    if (ws) begin
                        closed = 1'b1;
                    end else if (quote) begin
                        nxt.status = qlt_pkg::ST_QUOTE_ERR;
                        nxt.phase  = qlt_pkg::PH_DONE;
                    end else begin
                        content = 1'b1;
                        nxt.esc = (i_char == qlt_pkg::CHR_BSLASH);
                    end
                end
                qlt_pkg::PH_QUOTED: begin
                    if (i_char == close_chr) begin
                        closed = 1'b1;
                    end else begin
                        content = 1'b1;
                        nxt.esc = (i_char == qlt_pkg::CHR_BSLASH);
                    end
                end
                default: begin
                    nxt.phase = i_state.phase;
                end
            endcase
        end

        if (content || closed) begin
            idx = i_state.count;
        end
        if (closed) begin
            if (i_state.count != qlt_pkg::CNT_MAX) begin
                nxt.count = i_state.count + qlt_pkg::CNT_W'(1);
            end
            nxt.quote_dbl = 1'b0;
            nxt.phase     = qlt_pkg::PH_START;
            if (nxt.count >= lim) begin
                nxt.status = qlt_pkg::ST_LIMIT;
                nxt.phase  = qlt_pkg::PH_DONE;
            end
        end
    end

    always_comb begin
        o_result.char_out    = i_char;
        o_result.in_token    = content;
        o_result.token_close = closed;
        o_result.token_index = idx;
        o_result.token_count = nxt.count;
        o_result.line_status = nxt.status;
        o_state              = i_last ? qlt_pkg::STATE_RST : nxt;
    end

endmodule

`default_nettype wire

FILE: rtl/quoted_line_tokenizer.sv
// Top level of the quoted line tokenizer: request registers, line state, APB register.
//
//  channel  | dir | handshake          | payload
//  ---------+-----+--------------------+-----------------------------------------
//  s_*      | in  | s_tvalid/s_tready  | tdata char_in, tlast is_last
//  m_*      | out | m_tvalid/m_tready  | tdata result fields, tlast line_end
//  apb      | in  | psel/penable       | max_tokens at address 0
//
// One byte per cycle while m_tready does not stall; a request passes the input register,
// then the result register with the line state update, before it appears on m_*.
// Reset (synchronous) empties both registers, clears the line state and sets
// max_tokens to 10. A stalled m_tready holds the result; the input register
// still takes one more request behind it.
`default_nettype none

module quoted_line_tokenizer (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        s_tvalid,
    output var  logic        s_tready,
    input  wire logic [7:0]  s_tdata,   // [7:0] char_in
    input  wire logic        s_tlast,
    output var  logic        m_tvalid,
    input  wire logic        m_tready,
    // [7:0] char_out, [8] in_token, [9] token_close, [13:10] token_index,
    // [17:14] token_count, [19:18] line_status, [23:20] zero
    output var  logic [23:0] m_tdata,
    output var  logic        m_tlast,
    input  wire logic        psel,
    input  wire logic        penable,
    input  wire logic        pwrite,
    input  wire logic [2:0]  paddr,
    input  wire logic [31:0] pwdata,
    output var  logic [31:0] prdata,
    output var  logic        pready
);

    logic                r_in_valid;
    logic [7:0]          r_in_char;
    logic                r_in_last;
    logic                r_out_valid;
    qlt_pkg::t_result    r_out;
    logic                r_out_last;
    qlt_pkg::t_state     r_state;
    logic [3:0]          r_max_tokens;
    qlt_pkg::t_state     n_state;
    qlt_pkg::t_result    n_out;
    logic                adv;
    logic                reg_sel;

    assign adv      = r_in_valid && (!r_out_valid || m_tready);
    assign s_tready = !r_in_valid || adv;
    assign reg_sel  = (paddr[2] == qlt_pkg::REG_MAX_TOKENS);

    qlt_step u_step (
        .i_state      (r_state),
        .i_char       (r_in_char),
        .i_last       (r_in_last),
        .i_max_tokens (r_max_tokens),
        .o_state      (n_state),
        .o_result     (n_out)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (s_tready) begin
            r_in_valid <= s_tvalid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (s_tvalid && s_tready) begin
            r_in_char <= s_tdata;
            r_in_last <= s_tlast;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
            r_state     <= qlt_pkg::STATE_RST;
        end else if (adv) begin
            r_out_valid <= 1'b1;
            r_state     <= n_state;
        end else if (m_tready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (adv) begin
            r_out      <= n_out;
            r_out_last <= r_in_last;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_max_tokens <= qlt_pkg::MAX_TOKENS_RST;
        end else if (psel && penable && pwrite && pready && reg_sel) begin
            r_max_tokens <= pwdata[3:0];
        end
    end

    assign m_tvalid = r_out_valid;
    assign m_tdata  = {4'd0, r_out};
    assign m_tlast  = r_out_last;
    assign pready   = 1'b1;
    assign prdata   = reg_sel ? {28'd0, r_max_tokens} : 32'd0;

endmodule

`default_nettype wire

FILE: rtl/qlt_checker.sv
// Port-level checks of the quoted line tokenizer, bound to the top level.
`default_nettype none
`include "quoted_line_tokenizer_macros.svh"

module qlt_checker (
    input wire logic        i_clk,
    input wire logic        i_rst_n,
    input wire logic        m_tvalid,
    input wire logic        m_tready,
    input wire logic [23:0] m_tdata,
    input wire logic        m_tlast
);

    `QLT_ASSERT_NXT(a_out_hold, i_clk, i_rst_n, m_tvalid && !m_tready, m_tvalid && $stable(m_tdata) && $stable(m_tlast))
    `QLT_ASSERT_IMP(a_flags_excl, i_clk, i_rst_n, m_tvalid, !(m_tdata[8] && m_tdata[9]))
    `QLT_ASSERT_IMP(a_idx_zero, i_clk, i_rst_n, m_tvalid && !m_tdata[8] && !m_tdata[9], m_tdata[13:10] == 4'd0)
    `QLT_ASSERT_IMP(a_limit_cnt, i_clk, i_rst_n, m_tvalid && m_tdata[19:18] == qlt_pkg::ST_LIMIT, m_tdata[17:14] != 4'd0)

endmodule

bind quoted_line_tokenizer qlt_checker u_qlt_checker (
    .i_clk    (i_clk),
    .i_rst_n  (i_rst_n),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tlast  (m_tlast)
);

`default_nettype wire

FILE: verif/quoted_line_tokenizer_test.sv
// Stream testbench of the quoted line tokenizer: directed and random text lines, in-order result checks.
module quoted_line_tokenizer_test;
    import qlt_pkg::*;

    typedef struct {
        logic [7:0] ch;
        logic       last;
    } line_byte_t;

    typedef struct {
        t_result res;
        logic    last;
    } token_mark_t;

    localparam int STALL_LIMIT = 3000;
    localparam int HOLD_CYCLES = 300;
    localparam int DRAIN_CYCLES = 4;

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        s_tvalid = 1'b0;
    logic        s_tready;
    logic [7:0]  s_tdata = '0;      // [7:0] char_in
    logic        s_tlast = 1'b0;
    logic        m_tvalid;
    logic        m_tready = 1'b0;
    // [7:0] char_out, [8] in_token, [9] token_close, [13:10] token_index,
    // [17:14] token_count, [19:18] line_status, [23:20] zero
    logic [23:0] m_tdata;
    logic        m_tlast;
    logic        psel = 1'b0;
    logic        penable = 1'b0;
    logic        pwrite = 1'b0;
    logic [2:0]  paddr = '0;
    logic [31:0] pwdata = '0;
    logic [31:0] prdata;
    logic        pready;

    quoted_line_tokenizer u_top (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tlast  (s_tlast),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tlast  (m_tlast),
        .psel     (psel),
        .penable  (penable),
        .pwrite   (pwrite),
        .paddr    (paddr),
        .pwdata   (pwdata),
        .prdata   (prdata),
        .pready   (pready)
    );

    line_byte_t  line_bytes_q[$];
    token_mark_t token_marks_q[$];

    int   send_idle_pct = 0;
    int   recv_idle_pct = 0;
    int   errors = 0;
    int   stall_cycles = 0;
    int   hold_cnt = 0;
    logic hold_req = 1'b0;
    logic hold_ack = 1'b0;

    // tokenizer state mirror
    logic [3:0] max_tok = MAX_TOKENS_RST;
    t_phase     tk_phase = PH_LEAD;
    logic       tk_dq = 1'b0;
    logic       tk_esc = 1'b0;
    logic [3:0] tk_count = '0;
    t_status    tk_status = ST_OK;

    token_mark_t want;
    t_result     got;

    initial begin
        forever #1 i_clk = ~i_clk;
    end

    function automatic logic is_space(logic [7:0] c);
        return c == CHR_SPACE || (c >= CHR_TAB && c <= CHR_CR);
    endfunction

    function automatic logic is_quote(logic [7:0] c);
        return c == CHR_SQUOTE || c == CHR_DQUOTE;
    endfunction

    task automatic tokenize_byte(input logic [7:0] c, input logic last);
        token_mark_t m;
        logic        content;
        logic        closed;
        logic [3:0]  lim;
        m.res = '0;
        m.last = last;
        content = 1'b0;
        closed = 1'b0;
        lim = (max_tok == '0) ? 4'd1 : max_tok;
        if (tk_esc && (tk_phase == PH_TOKEN || tk_phase == PH_QUOTED)) begin
            tk_esc = 1'b0;
            content = 1'b1;
        end else begin
            tk_esc = 1'b0;
            case (tk_phase)
                PH_LEAD, PH_START: begin
                    if (!is_space(c)) begin
                        if (tk_phase == PH_LEAD && c == CHR_HASH) begin
                            tk_status = ST_COMMENT;
                            tk_phase = PH_DONE;
                        end else if (is_quote(c)) begin
                            tk_dq = (c == CHR_DQUOTE);
                            tk_phase = PH_QUOTED;
                        end else begin
                            content = 1'b1;
                            tk_phase = PH_TOKEN;
                            tk_esc = (c == CHR_BSLASH);
                        end
                    end
                end
                PH_TOKEN: begin
                    if (is_space(c)) begin
                        closed = 1'b1;
                    end else if (is_quote(c)) begin
                        tk_status = ST_QUOTE_ERR;
                        tk_phase = PH_DONE;
                    end else begin
                        content = 1'b1;
                        tk_esc = (c == CHR_BSLASH);
                    end
                end
                PH_QUOTED: begin
                    if (c == (tk_dq ? CHR_DQUOTE : CHR_SQUOTE)) begin
                        closed = 1'b1;
                    end else begin
                        content = 1'b1;
                        tk_esc = (c == CHR_BSLASH);
                    end
                end
                default: ;
            endcase
        end
        if (content || closed) m.res.token_index = tk_count;
        if (closed) begin
            if (tk_count != CNT_MAX) tk_count = tk_count + 1'b1;
            tk_dq = 1'b0;
            tk_phase = PH_START;
            if (tk_count >= lim) begin
                tk_status = ST_LIMIT;
                tk_phase = PH_DONE;
            end
        end
        m.res.char_out = c;
        m.res.in_token = content;
        m.res.token_close = closed;
        m.res.token_count = tk_count;
        m.res.line_status = tk_status;
        token_marks_q.push_back(m);
        if (last) begin
            tk_phase = PH_LEAD;
            tk_dq = 1'b0;
            tk_esc = 1'b0;
            tk_count = '0;
            tk_status = ST_OK;
        end
    endtask

    // sender
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            s_tvalid <= 1'b0;
        end else begin
            if (s_tvalid && s_tready) tokenize_byte(s_tdata, s_tlast);
            if (!s_tvalid || s_tready) begin
                if (line_bytes_q.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
                    s_tvalid <= 1'b1;
                    s_tdata <= line_bytes_q[0].ch;
                    s_tlast <= line_bytes_q[0].last;
                    line_bytes_q.pop_front();
                end else begin
                    s_tvalid <= 1'b0;
                end
            end
        end
    end

    // receiver and checker
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            m_tready <= 1'b0;
        end else begin
            if (m_tvalid && m_tready) begin
                got = t_result'(m_tdata[19:0]);
                if (token_marks_q.size() == 0) begin
                    if (errors < 10) $display("unexpected result: tdata %h last %b",
                                              m_tdata, m_tlast);
                    errors++;
                end else begin
                    want = token_marks_q.pop_front();
                    if (got.char_out !== want.res.char_out ||
                        got.in_token !== want.res.in_token ||
                        got.token_close !== want.res.token_close ||
                        got.token_index !== want.res.token_index ||
                        got.token_count !== want.res.token_count ||
                        got.line_status !== want.res.line_status ||
                        m_tlast !== want.last || m_tdata[23:20] !== 4'h0) begin
                        if (errors < 10) begin
                            $display("mismatch exp: char %h in %b close %b idx %0d cnt %0d st %0d end %b",
                                     want.res.char_out, want.res.in_token,
                                     want.res.token_close, want.res.token_index,
                                     want.res.token_count, want.res.line_status, want.last);
                            $display("         got: char %h in %b close %b idx %0d cnt %0d st %0d end %b pad %h",
                                     got.char_out, got.in_token, got.token_close,
                                     got.token_index, got.token_count, got.line_status,
                                     m_tlast, m_tdata[23:20]);
                        end
                        errors++;
                    end
                end
            end
            if (hold_req != hold_ack) begin
                hold_ack <= hold_req;
                hold_cnt <= HOLD_CYCLES;
                m_tready <= 1'b0;
            end else if (hold_cnt != 0) begin
                hold_cnt <= hold_cnt - 1;
                m_tready <= 1'b0;
            end else begin
                m_tready <= ($urandom_range(99) >= recv_idle_pct);
            end
        end
    end

    // watchdog
    always @(posedge i_clk) begin
        if ((s_tvalid && s_tready) || (m_tvalid && m_tready) ||
            (line_bytes_q.size() == 0 && !s_tvalid && token_marks_q.size() == 0)) begin
            stall_cycles <= 0;
        end else begin
            stall_cycles <= stall_cycles + 1;
            if (stall_cycles == STALL_LIMIT) begin
                $display("quoted_line_tokenizer_test: errors");
                $finish;
            end
        end
    end

    task automatic push_byte(input logic [7:0] c, input logic last);
        line_byte_t b;
        b.ch = c;
        b.last = last;
        line_bytes_q.push_back(b);
    endtask

    task automatic push_text(input string s, input logic last_at_end);
        for (int i = 0; i < s.len(); i++) push_byte(s[i], last_at_end && i == s.len() - 1);
    endtask

    task automatic drain();
        while (line_bytes_q.size() != 0 || s_tvalid || token_marks_q.size() != 0)
            @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
    endtask

    task automatic apb_write(input logic [3:0] value);
        @(posedge i_clk);
        psel <= 1'b1;
        penable <= 1'b0;
        pwrite <= 1'b1;
        paddr <= {REG_MAX_TOKENS, 2'b00};
        pwdata <= {28'h0, value};
        @(posedge i_clk);
        penable <= 1'b1;
        do @(posedge i_clk); while (!pready);
        psel <= 1'b0;
        penable <= 1'b0;
        pwrite <= 1'b0;
        max_tok = value;
    endtask

    function automatic logic [7:0] space_byte();
        int k;
        k = $urandom_range(5);
        return (k == 0) ? CHR_SPACE : CHR_TAB + 8'(k - 1);
    endfunction

    function automatic logic [7:0] plain_byte();
        logic [7:0] c;
        if ($urandom_range(9) == 0) return CHR_BSLASH;
        do c = 8'($urandom_range(255)); while (is_space(c) || is_quote(c));
        return c;
    endfunction

    // one line of text, mostly well formed, sometimes noise or broken
    task automatic compose_line(output int n);
        logic [7:0] text[$];
        logic [7:0] c;
        logic [7:0] q;
        int         kind;
        int         ntok;
        kind = $urandom_range(99);
        if (kind < 8) begin
            repeat ($urandom_range(1, 12)) text.push_back(8'($urandom_range(255)));
        end else begin
            repeat ($urandom_range(0, 2)) text.push_back(space_byte());
            if (kind < 14) begin
                text.push_back(CHR_HASH);
                repeat ($urandom_range(0, 5)) text.push_back(8'($urandom_range(255)));
            end else begin
                ntok = ($urandom_range(9) == 0) ? $urandom_range(10, 17) : $urandom_range(0, 5);
                for (int t = 0; t < ntok; t++) begin
                    if (t != 0) repeat ($urandom_range(1, 2)) text.push_back(space_byte());
                    if ($urandom_range(2) == 0) begin
                        q = $urandom_range(1) ? CHR_DQUOTE : CHR_SQUOTE;
                        text.push_back(q);
                        repeat ($urandom_range(0, 4)) begin
                            c = 8'($urandom_range(255));
                            if (c == q) c = CHR_BSLASH;
                            text.push_back(c);
                            if (c == CHR_BSLASH) text.push_back($urandom_range(1) ? q
                                                               : 8'($urandom_range(255)));
                        end
                        if ($urandom_range(19) != 0) text.push_back(q);
                    end else begin
                        repeat ($urandom_range(1, 4)) begin
                            c = plain_byte();
                            text.push_back(c);
                            if (c == CHR_BSLASH) text.push_back(8'($urandom_range(255)));
                        end
                        if ($urandom_range(19) == 0)
                            text.push_back($urandom_range(1) ? CHR_DQUOTE : CHR_SQUOTE);
                    end
                end
                if ($urandom_range(1) == 0) text.push_back(space_byte());
            end
        end
        if (text.size() == 0) text.push_back(space_byte());
        for (int i = 0; i < text.size(); i++) push_byte(text[i], i == text.size() - 1);
        n = text.size();
    endtask

    logic [3:0] phase_limit[6];

    initial begin
        int sent;
        int n;
        repeat (10) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // directed lines at the reset limit, then at limits 0, 15 and 2
        push_text(" #a", 1'b1);
        push_text("a\"b", 1'b1);
        push_text("'\\''", 1'b0);
        push_byte(8'hFF, 1'b0);
        push_text(" \"", 1'b0);
        push_byte(8'h00, 1'b0);
        push_text("\"\\", 1'b1);
        drain();
        apb_write(4'd0);
        push_text("ab c", 1'b1);
        drain();
        apb_write(4'd15);
        push_text("a b c", 1'b0);
        drain();
        apb_write(4'd2);
        push_text(" d", 1'b1);

        phase_limit[0] = 4'd15;
        phase_limit[1] = 4'd1;
        phase_limit[2] = 4'($urandom_range(1, 15));
        phase_limit[3] = 4'($urandom_range(1, 15));
        phase_limit[4] = 4'd3;
        phase_limit[5] = 4'd15;
        for (int ph = 0; ph < 6; ph++) begin
            drain();
            case (ph / 2)
                0: begin
                    send_idle_pct = 11;
                    recv_idle_pct = 66;
                end
                1: begin
                    send_idle_pct = 66;
                    recv_idle_pct = 11;
                end
                default: begin
                    send_idle_pct = 0;
                    recv_idle_pct = 0;
                end
            endcase
            apb_write(phase_limit[ph]);
            if (ph == 0 || ph == 4) hold_req = ~hold_req;
            sent = 0;
            while (sent < 165) begin
                compose_line(n);
                sent += n;
            end
        end
        drain();
        errors += token_marks_q.size();
        if (errors == 0) begin
            $display("quoted_line_tokenizer_test: clean");
        end else begin
            $display("quoted_line_tokenizer_test: errors");
        end
        $finish;
    end
endmodule

FILE: filelist.f
+incdir+rtl
rtl/qlt_pkg.sv
rtl/qlt_step.sv
rtl/quoted_line_tokenizer.sv
rtl/qlt_checker.sv
verif/quoted_line_tokenizer_test.sv
